/* src/fsa_pkg.sv */
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and helpers for the frame stack averager
// Widths, register indexes, channel bundles and the radix-2 division step
// that the averaging divider pipeline repeats.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 24;
  localparam int PIX_W      = 16;
  localparam int FRM_W      = 8;
  localparam int FCNT_W     = 9;
  localparam int PCNT_W     = 17;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CHANNELS   = 3;
  localparam int MAX_PIXELS = 65536;
  localparam int MAX_FRAMES = 256;

  // Divider: the divisor is at most 256, so it needs 9 bits; the remainder below it uses the same width.
  localparam int DIV_W      = FCNT_W;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = SUM_W / DIV_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 1'b1;

  // Element 0 is red, 1 green, 2 blue.
  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample3_t;
  typedef logic [CHANNELS-1:0][SUM_W-1:0]    sum3_t;

  typedef struct packed {
    sum3_t sum;
    logic  done;
  } acc_item_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [SUM_W-1:0] num;
  } div_lane_t;

  // Restoring division, DIV_BITS quotient bits per call. Quotient bits shift
  // into the low end of num as dividend bits leave the top.
  function automatic div_lane_t div_step(div_lane_t cur, logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    div_lane_t      nx;
    nx = cur;
    for (int k = 0; k < DIV_BITS; k++) begin
      t      = {nx.rem, nx.num[SUM_W-1]};
      nx.num = {nx.num[SUM_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t         = t - {1'b0, d};
        nx.num[0] = 1'b1;
      end
      nx.rem = t[DIV_W-1:0];
    end
    return nx;
  endfunction

endpackage

/* src/frame_stack_averager_unit.sv */
// ----------------------------------------------------------------------------
// frame_stack_averager_unit: temporal averaging of stacked RGB frames
//
//   port group   direction  payload
//   s_*          in         one pixel of the current frame, raster order
//   m_*          out        averaged pixel, last frame only; tlast on final
//   cfg_*        in         frame_count (index 0), pixel_count (index 1)
//
// One pixel is taken per cycle unless the pipeline is stalled; a result passes
// the frame store read, accumulate and six divider stages on its way out.
// The frame store is read when a pixel is taken and written when the pixel
// leaves the accumulate stage, which waits while a result there is held.
// Reset clears counters and valid bits; the frame store needs no clearing.
// Stalls on the output side only stop stages that are full; pixels of earlier
// frames produce no result and keep flowing past a stalled output.
// ----------------------------------------------------------------------------
module frame_stack_averager_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsa_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [47:0]                    s_tdata,   // red_in, green_in, blue_in
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [47:0]                    m_tdata,   // red_avg, green_avg, blue_avg
  output logic                           m_tlast    // image_done
);
  import fsa_pkg::*;

  logic              acc_valid;
  logic              acc_ready;
  acc_item_t         acc_item;
  logic [FCNT_W-1:0] divisor;
  sample3_t          avg;

  fsa_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_samples (sample3_t'(s_tdata)),
    .out_valid  (acc_valid),
    .out_ready  (acc_ready),
    .out_item   (acc_item),
    .divisor    (divisor)
  );

  fsa_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .divisor   (divisor),
    .in_valid  (acc_valid),
    .in_ready  (acc_ready),
    .in_item   (acc_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_avg   (avg),
    .out_done  (m_tlast)
  );

  assign m_tdata = avg;

endmodule

/* src/fsa_accum.sv */
// ----------------------------------------------------------------------------
// fsa_accum: frame store and per-pixel accumulation
// Holds the configuration and position counters, reads the running sums at
// transfer time, adds the new samples one stage later and writes them back.
// Sums of the last frame are passed on for division.
// ----------------------------------------------------------------------------
module fsa_accum (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsa_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fsa_pkg::sample3_t              in_samples,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fsa_pkg::acc_item_t             out_item,
  output logic [fsa_pkg::FCNT_W-1:0]     divisor
);
  import fsa_pkg::*;

  logic [FCNT_W-1:0] frame_count;
  logic [PCNT_W-1:0] pixel_count;
  logic [PIX_W-1:0]  pixel_index;
  logic [FRM_W-1:0]  frame_index;

  logic [FCNT_W-1:0] frames_used;
  logic [PCNT_W-1:0] pixels_used;
  logic [PIX_W-1:0]  pix_last;
  logic [FRM_W-1:0]  frm_last;
  logic              last_pix;
  logic              in_fire;

  sum3_t             mem [MAX_PIXELS];
  sum3_t             rd_data;

  // Stage A: item waiting for its read data to be summed.
  logic              a_valid;
  logic [PIX_W-1:0]  a_idx;
  sample3_t          a_samples;
  logic              a_first;
  logic              a_emit;
  logic              a_done;
  logic              a_byp;
  sum3_t             a_byp_sum;
  sum3_t             a_sum;
  sum3_t             a_base;
  logic              a_adv;

  // Stage B: finished sums of the last frame.
  logic              b_valid;
  acc_item_t         b_item;
  logic              b_open;

  always_comb begin
    if (frame_count == '0) begin
      frames_used = FCNT_W'(1);
    end else if (frame_count > FCNT_W'(MAX_FRAMES)) begin
      frames_used = FCNT_W'(MAX_FRAMES);
    end else begin
      frames_used = frame_count;
    end
    if (pixel_count == '0) begin
      pixels_used = PCNT_W'(1);
    end else if (pixel_count > PCNT_W'(MAX_PIXELS)) begin
      pixels_used = PCNT_W'(MAX_PIXELS);
    end else begin
      pixels_used = pixel_count;
    end
  end

  assign pix_last = PIX_W'(pixels_used - PCNT_W'(1));
  assign frm_last = FRM_W'(frames_used - FCNT_W'(1));
  assign last_pix = (pixel_index == pix_last);
  assign divisor  = frames_used;

  assign b_open   = !b_valid || out_ready;
  assign a_adv    = a_valid && (!a_emit || b_open);
  assign in_ready = !a_valid || a_adv;
  assign in_fire  = in_valid && in_ready;

  assign a_base = a_byp ? a_byp_sum : rd_data;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (a_first) begin
        a_sum[c] = {{(SUM_W-SAMPLE_W){1'b0}}, a_samples[c]};
      end else begin
        a_sum[c] = a_base[c] + {{(SUM_W-SAMPLE_W){1'b0}}, a_samples[c]};
      end
    end
  end

  // Read at transfer time, write back when the item leaves stage A.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= mem[pixel_index];
    end
    if (a_adv) begin
      mem[a_idx] <= a_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FCNT_W'(1);
      pixel_count <= PCNT_W'(1);
      pixel_index <= '0;
      frame_index <= '0;
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_COUNT: frame_count <= cfg_data[FCNT_W-1:0];
          CFG_PIXEL_COUNT: pixel_count <= cfg_data[PCNT_W-1:0];
          default: ;
        endcase
        pixel_index <= '0;
        frame_index <= '0;
      end else if (in_fire) begin
        if (last_pix) begin
          pixel_index <= '0;
          frame_index <= (frame_index == frm_last) ? '0 : frame_index + FRM_W'(1);
        end else begin
          pixel_index <= pixel_index + PIX_W'(1);
        end
      end
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (b_open) begin
        b_valid <= a_adv && a_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_idx     <= pixel_index;
      a_samples <= in_samples;
      a_first   <= (frame_index == '0);
      a_emit    <= (frame_index == frm_last);
      a_done    <= last_pix;
      // The write leaving stage A in this same cycle is missed by the read.
      a_byp     <= a_adv && (a_idx == pixel_index);
      a_byp_sum <= a_sum;
    end
    if (b_open && a_adv && a_emit) begin
      b_item.sum  <= a_sum;
      b_item.done <= a_done;
    end
  end

  assign out_valid = b_valid;
  assign out_item  = b_item;

`ifndef SYNTHESIS
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (pixel_index == '0) && (frame_index == '0))
    else $error("position counters not cleared by a register write");

  a_pix_range: assert property (@(posedge clk) disable iff (rst)
    (pixel_index <= pix_last) && (frame_index <= frm_last))
    else $error("position counters outside the configured image");

  a_pix_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && !cfg_we && !last_pix |=> pixel_index == $past(pixel_index) + PIX_W'(1))
    else $error("pixel index did not advance by one");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_emit && !b_open |=> a_valid && $stable(a_idx))
    else $error("stage A item lost while the result stage is full");
`endif

endmodule

/* src/fsa_divider.sv */
// ----------------------------------------------------------------------------
// fsa_divider: pipelined truncating divide of the channel sums
// Six stages, four restoring-division steps each, three channel lanes in
// parallel. Each stage holds its item until the next stage has room.
// ----------------------------------------------------------------------------
module fsa_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fsa_pkg::FCNT_W-1:0]  divisor,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fsa_pkg::acc_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fsa_pkg::sample3_t           out_avg,
  output logic                        out_done
);
  import fsa_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] st_valid;
  logic [DIV_STAGES-1:0] st_ready;
  logic [DIV_STAGES-1:0] st_done;
  div_lane_t             st_lane [DIV_STAGES][CHANNELS];

  logic [DIV_STAGES-1:0] up_valid;
  logic [DIV_STAGES-1:0] up_done;
  div_lane_t             up_lane [DIV_STAGES][CHANNELS];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    if (i == LAST) begin : g_tail
      assign st_ready[i] = !st_valid[i] || out_ready;
    end else begin : g_mid
      assign st_ready[i] = !st_valid[i] || st_ready[i+1];
    end
    if (i == 0) begin : g_head
      assign up_valid[i] = in_valid;
      assign up_done[i]  = in_item.done;
      for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        assign up_lane[i][c] = '{rem: '0, num: in_item.sum[c]};
      end
    end else begin : g_body
      assign up_valid[i] = st_valid[i-1];
      assign up_done[i]  = st_done[i-1];
      for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        assign up_lane[i][c] = st_lane[i-1][c];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[i] <= 1'b0;
      end else if (st_ready[i]) begin
        st_valid[i] <= up_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (st_ready[i] && up_valid[i]) begin
        st_done[i] <= up_done[i];
        for (int c = 0; c < CHANNELS; c++) begin
          st_lane[i][c] <= div_step(up_lane[i][c], divisor);
        end
      end
    end
  end

  assign in_ready  = st_ready[0];
  assign out_valid = st_valid[LAST];
  assign out_done  = st_done[LAST];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      out_avg[c] = st_lane[LAST][c].num[SAMPLE_W-1:0];
    end
  end

endmodule

/* dv/frame_stack_averager_unit_test.sv */
// ----------------------------------------------------------------------------
// frame_stack_averager_unit_test: self-checking bench for the frame averager
// Streams RGB pixels of stacked frames through the block under several frame
// and pixel counts. A scoreboard keeps its own per-pixel sums and checks each
// averaged pixel and the end-of-image flag against its prediction.
// ----------------------------------------------------------------------------
module frame_stack_averager_unit_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int PLAN_STEP     = 520;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int REPORT_CAP    = 200;

  typedef struct {
    logic [fsa_pkg::SAMPLE_W-1:0] red;
    logic [fsa_pkg::SAMPLE_W-1:0] green;
    logic [fsa_pkg::SAMPLE_W-1:0] blue;
    logic                         done;
  } pixel_avg_t;

  class stack_average_board;
    int unsigned frame_total;
    int unsigned pixel_total;
    int unsigned frame_pos;
    int unsigned pixel_pos;
    bit [fsa_pkg::SUM_W-1:0] red_sum   [fsa_pkg::MAX_PIXELS];
    bit [fsa_pkg::SUM_W-1:0] green_sum [fsa_pkg::MAX_PIXELS];
    bit [fsa_pkg::SUM_W-1:0] blue_sum  [fsa_pkg::MAX_PIXELS];
    pixel_avg_t  averages_due[$];
    int unsigned averages_made;
    int unsigned mismatches;

    function new();
      frame_total   = 1;
      pixel_total   = 1;
      frame_pos     = 0;
      pixel_pos     = 0;
      averages_made = 0;
      mismatches    = 0;
    endfunction

    // Zero counts act as one and large counts saturate; any write restarts
    // the stack with a first frame.
    function void load_reg(logic [fsa_pkg::CFG_IDX_W-1:0] idx,
                           logic [fsa_pkg::CFG_W-1:0] value);
      if (idx == fsa_pkg::CFG_FRAME_COUNT) begin
        frame_total = value[fsa_pkg::FCNT_W-1:0];
        if (frame_total == 0) frame_total = 1;
        if (frame_total > fsa_pkg::MAX_FRAMES) frame_total = fsa_pkg::MAX_FRAMES;
      end else begin
        pixel_total = value[fsa_pkg::PCNT_W-1:0];
        if (pixel_total == 0) pixel_total = 1;
        if (pixel_total > fsa_pkg::MAX_PIXELS) pixel_total = fsa_pkg::MAX_PIXELS;
      end
      frame_pos = 0;
      pixel_pos = 0;
    endfunction

    function void take_pixel(logic [fsa_pkg::SAMPLE_W-1:0] r,
                             logic [fsa_pkg::SAMPLE_W-1:0] g,
                             logic [fsa_pkg::SAMPLE_W-1:0] b);
      pixel_avg_t avg;
      if (frame_pos == 0) begin
        red_sum[pixel_pos]   = r;
        green_sum[pixel_pos] = g;
        blue_sum[pixel_pos]  = b;
      end else begin
        red_sum[pixel_pos]   += r;
        green_sum[pixel_pos] += g;
        blue_sum[pixel_pos]  += b;
      end
      if (frame_pos == frame_total - 1) begin
        avg.red   = 16'(red_sum[pixel_pos] / frame_total);
        avg.green = 16'(green_sum[pixel_pos] / frame_total);
        avg.blue  = 16'(blue_sum[pixel_pos] / frame_total);
        avg.done  = (pixel_pos == pixel_total - 1);
        averages_due.push_back(avg);
        averages_made++;
      end
      if (pixel_pos == pixel_total - 1) begin
        pixel_pos = 0;
        frame_pos = (frame_pos + 1 == frame_total) ? 0 : frame_pos + 1;
      end else begin
        pixel_pos++;
      end
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_average(logic [47:0] data, logic last);
      pixel_avg_t want;
      if (averages_due.size() == 0) begin
        flag_mismatch($sformatf("average %h arrived with none outstanding", data));
        return;
      end
      want = averages_due.pop_front();
      if (data[15:0] !== want.red)
        flag_mismatch($sformatf("red_avg %h, predicted %h", data[15:0], want.red));
      if (data[31:16] !== want.green)
        flag_mismatch($sformatf("green_avg %h, predicted %h", data[31:16], want.green));
      if (data[47:32] !== want.blue)
        flag_mismatch($sformatf("blue_avg %h, predicted %h", data[47:32], want.blue));
      if (last !== want.done)
        flag_mismatch($sformatf("image_done %b, predicted %b", last, want.done));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [fsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fsa_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [47:0]                   s_tdata = '0;   // red_in, green_in, blue_in
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [47:0]                   m_tdata;        // red_avg, green_avg, blue_avg
  logic                          m_tlast;        // image_done

  stack_average_board board = new();

  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned random_sent = 0;
  int          tx_idle_pct = 16;
  int          rx_idle_pct = 66;
  int          holds_requested = 0;
  int          holds_served = 0;
  int          stall_left = 0;

  frame_stack_averager_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // A requested hold-off keeps tready low long enough for the block to fill
  // and push back on the pixel stream.
  always @(negedge clk) begin
    if (holds_served != holds_requested) begin
      holds_served++;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (m_tvalid === 1'b1 && m_tready) board.check_average(m_tdata, m_tlast);
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    do @(posedge clk); while (s_tready !== 1'b1);
    board.take_pixel(r, g, b);
    pixels_sent++;
    if (pixels_sent == PLAN_STEP) begin
      tx_idle_pct = 66;
      rx_idle_pct = 16;
    end else if (pixels_sent == 2 * PLAN_STEP) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    @(negedge clk);
  endtask

  // Pixels of early frames give no result, so allow the pipeline to empty
  // after the last average has come out.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.averages_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reconfigure(input int unsigned frame_reg, input int unsigned pixel_reg);
    logic [fsa_pkg::CFG_IDX_W-1:0] idx;
    logic [fsa_pkg::CFG_W-1:0]     value;
    bit                            pixel_first;
    settle();
    pixel_first = $urandom_range(1);
    for (int k = 0; k < 2; k++) begin
      if ((k == 0) == pixel_first) begin
        idx   = fsa_pkg::CFG_PIXEL_COUNT;
        value = pixel_reg[fsa_pkg::CFG_W-1:0];
      end else begin
        idx   = fsa_pkg::CFG_FRAME_COUNT;
        value = frame_reg[fsa_pkg::CFG_W-1:0];
      end
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value;
      @(negedge clk);
      board.load_reg(idx, value);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input int unsigned count, input int pause_at, input bit all_max);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      if (all_max) send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      else send_pixel(pick_sample(), pick_sample(), pick_sample());
      random_sent++;
    end
  endtask

  initial begin
    int unsigned f_reg, p_reg, f_eff, p_eff, total;
    int          pause, phase;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset counts: one frame of one pixel, so every pixel is its own image.
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h5555, 16'hAAAA, 16'h0001);

    // Zero counts behave as one.
    reconfigure(0, 0);
    send_pixel(16'hAAAA, 16'h5555, 16'h8000);

    // Two frames of two pixels; odd sums check truncation.
    reconfigure(2, 2);
    send_pixel(16'hFFFF, 16'h0000, 16'h0001);
    send_pixel(16'h0001, 16'hFFFF, 16'hAAAA);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(16'h0002, 16'hFFFF, 16'h5555);

    // Abandon a stack part way; the next write restarts with a first frame.
    reconfigure(3, 2);
    send_pixel(16'h1234, 16'h8765, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0F0F, 16'hF0F0, 16'h7FFF);
    reconfigure(2, 1);
    send_pixel(16'h0003, 16'hFFFE, 16'h8001);
    send_pixel(16'h0004, 16'hFFFF, 16'h7FFF);

    // Pixel count above the store size saturates, and the store size itself.
    reconfigure(1, 17'h1FFFF);
    send_pixel(16'hC3C3, 16'h3C3C, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h5A5A);
    send_pixel(16'hFFFF, 16'h0000, 16'hA5A5);
    reconfigure(1, fsa_pkg::MAX_PIXELS);
    send_pixel(16'h8000, 16'h0001, 16'hFFFF);
    send_pixel(16'h7FFF, 16'hFFFE, 16'h0000);

    phase = 0;
    while (random_sent < RANDOM_ITEMS || board.averages_made < 60) begin
      case (phase)
        1: begin
          reconfigure(1, 16);
          holds_requested++;
          send_random(64, -1, 1'b0);
        end
        3: begin
          // Saturated frame count with full-scale samples gives the largest sum.
          reconfigure(511, 1);
          send_random(fsa_pkg::MAX_FRAMES, -1, 1'b1);
        end
        6: begin
          reconfigure(fsa_pkg::MAX_FRAMES, 1);
          send_random(fsa_pkg::MAX_FRAMES, $urandom_range(1, 255), 1'b0);
        end
        8: begin
          reconfigure($urandom_range(0, 1), $urandom_range(65537, 131071));
          send_random(24, -1, 1'b0);
        end
        11: begin
          reconfigure(1, fsa_pkg::MAX_PIXELS);
          send_random(24, -1, 1'b0);
        end
        default: begin
          f_reg = $urandom_range(0, 8);
          p_reg = $urandom_range(0, 16);
          f_eff = (f_reg == 0) ? 1 : f_reg;
          p_eff = (p_reg == 0) ? 1 : p_reg;
          total = f_eff * p_eff * $urandom_range(1, 3);
          // Now and then cut the last stack short.
          if ($urandom_range(99) < 15) total = total - $urandom_range(1, f_eff * p_eff);
          pause = ($urandom_range(9) == 0) ? int'($urandom_range(0, total)) : -1;
          reconfigure(f_reg, p_reg);
          send_random(total, pause, 1'b0);
        end
      endcase
      phase++;
    end

    s_tvalid <= 1'b0;
    while (board.averages_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
